// ----- sv/sidm_pkg.sv -----
// Package for the stream id map table: sizes, command and status codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps

package sidm_pkg;

  localparam int MAP_ENTRIES = 8;
  localparam int KEY_W       = 32;
  localparam int TRK_W       = 8;
  localparam int IDX_W       = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAP_ENTRIES + 1);
  localparam int ENT_W       = KEY_W + TRK_W;

  typedef enum logic {
    CMD_REGISTER = 1'b0,
    CMD_LOOKUP   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DECIDE,
    S_OUT
  } state_e;

endpackage

// ----- sv/sidm_if.sv -----
// Valid/ready channel interfaces for command beats and result beats.
// Depends on sidm_pkg.
`timescale 1ns / 1ps

interface sidm_in_if
  import sidm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [KEY_W-1:0] source_id;
  logic [TRK_W-1:0] track_id;

  modport source (output valid, output cmd, output source_id, output track_id, input ready);
  modport sink   (input valid, input cmd, input source_id, input track_id, output ready);
endinterface

interface sidm_out_if
  import sidm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [TRK_W-1:0] found_track;

  modport source (output valid, output status, output found_track, input ready);
  modport sink   (input valid, input status, input found_track, output ready);
endinterface

// ----- sv/sidm_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module sidm_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 40
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- sv/stream_id_map_table.sv -----
// Stream id map table top: maps a 32-bit source id to an 8-bit track id.
// Depends on sidm_pkg, sidm_if (channels) and sidm_ram (entry store).
// Flow: the input beat is taken in S_IDLE; each occupied slot scanned passes S_READ
//   then S_CMP; a hit goes straight to S_OUT, a scan that ends without a hit (or an
//   empty table) goes through S_DECIDE to S_OUT; a hit stops the scan early.
// Commands: one at a time; a new beat is taken only back in S_IDLE. The scan is set
//   by the single RAM read port: a read state plus a compare state per slot.
// Reset: async active low; clears the fill count (table empty) and the FSM. RAM
//   contents are not cleared; slots at or above the fill count are never compared.
`timescale 1ns / 1ps

module stream_id_map_table
  import sidm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  sidm_in_if.sink      in_i,
  sidm_out_if.source   out_o
);

  // Slots fill lowest-first and are never removed, so occupied slots are
  // exactly 0 .. fill_cnt-1; the count stands in for per-slot valid bits.
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   fill_cnt_q, fill_cnt_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   idx_nxt;

  // Captured command beat
  logic               cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [TRK_W-1:0]   trk_q;

  // Pending result, then output register
  status_e            res_status_q, res_status_d;
  logic [TRK_W-1:0]   res_track_q, res_track_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q;
  logic [TRK_W-1:0]   out_track_q;

  // RAM port signals
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic [ENT_W-1:0]   ram_rdata;
  logic               hit;
  logic               in_fire;
  logic               out_load;

  sidm_ram #(
    .DEPTH (MAP_ENTRIES),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  // Key compare against the slot read in the previous cycle
  assign hit     = (ram_rdata[ENT_W-1:TRK_W] == key_q);
  assign idx_nxt = CNT_W'(idx_q + 1'b1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (fill_cnt_q == '0) ? S_DECIDE : S_READ;
        end
      end
      S_READ:   state_d = S_CMP;
      S_CMP: begin
        if (hit) begin
          state_d = S_OUT;
        end else if (idx_nxt == fill_cnt_q) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_READ;
        end
      end
      S_DECIDE: state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM write control
  always_comb begin
    idx_d        = idx_q;
    fill_cnt_d   = fill_cnt_q;
    res_status_d = res_status_q;
    res_track_d  = res_track_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[IDX_W-1:0];
    ram_wdata    = {key_q, trk_q};
    case (state_q)
      S_IDLE: begin
        idx_d = '0;
      end
      S_CMP: begin
        if (hit) begin
          res_status_d = ST_OK;
          if (cmd_q == CMD_REGISTER) begin
            // Known key: overwrite track id in place
            ram_we      = 1'b1;
            res_track_d = '0;
          end else begin
            res_track_d = ram_rdata[TRK_W-1:0];
          end
        end else begin
          idx_d = idx_nxt;
        end
      end
      S_DECIDE: begin
        res_track_d = '0;
        if (cmd_q == CMD_LOOKUP) begin
          res_status_d = ST_MISS;
        end else if (fill_cnt_q == CNT_W'(MAP_ENTRIES)) begin
          res_status_d = ST_FULL;
        end else begin
          // New key goes to the lowest free slot
          res_status_d = ST_OK;
          ram_we       = 1'b1;
          ram_waddr    = fill_cnt_q[IDX_W-1:0];
          fill_cnt_d   = CNT_W'(fill_cnt_q + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_cnt_q   <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      fill_cnt_q   <= fill_cnt_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
      res_status_q <= res_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_track_q <= res_track_d;
    if (in_fire) begin
      cmd_q <= in_i.cmd;
      key_q <= in_i.source_id;
      trk_q <= in_i.track_id;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_track_q  <= res_track_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.found_track = out_track_q;

endmodule

// ----- sv/sidm_chk.sv -----
// Port-level checker for stream_id_map_table, attached by bind.
// Depends on sidm_pkg.
`timescale 1ns / 1ps

module sidm_chk
  import sidm_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [1:0]       status_i,
  input logic [TRK_W-1:0] found_track_i
);

  // Only the three defined status codes appear on a result beat
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == ST_OK || status_i == ST_FULL || status_i == ST_MISS))
    else $error("undefined status code");

  // Full and miss results carry a zero track id
  a_zero_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i == ST_FULL || status_i == ST_MISS)) |-> (found_track_i == '0))
    else $error("nonzero track on full or miss");

  // One command in flight: input closes after a beat is taken
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while a command is in flight");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(status_i) && $stable(found_track_i)))
    else $error("result beat changed while stalled");

endmodule

bind stream_id_map_table sidm_chk u_sidm_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .found_track_i (out_o.found_track)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for stream_id_map_table: directed table, then random beats
// with bursty idling on both channels. Depends on sidm_pkg, sidm_if and the DUT.
`timescale 1ns / 1ps

module testbench;
  import sidm_pkg::*;

  localparam int RAND_BEATS   = 800;
  localparam int QUIET_BEATS  = 120;   // tail with no idling on either side
  localparam int HOLD_AT_BEAT = 300;   // random beat that triggers the long output stall
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * MAP_ENTRIES + 24;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    status_e          status;
    logic [TRK_W-1:0] track;
  } map_result_t;

  // One directed command; pinned rows carry a result typed in by hand.
  typedef struct packed {
    cmd_e             cmd;
    logic [KEY_W-1:0] key;
    logic [TRK_W-1:0] trk;
    bit               pinned;
    status_e          pin_status;
    logic [TRK_W-1:0] pin_track;
  } map_row_t;

  localparam int DIR_ROWS = 24;

  map_row_t dir_rows [DIR_ROWS] = '{
    // empty table after reset: both key extremes miss
    '{CMD_LOOKUP,   32'h0000_0000, 8'hFF, 1'b1, ST_MISS, 8'h00},
    '{CMD_LOOKUP,   32'hFFFF_FFFF, 8'h00, 1'b1, ST_MISS, 8'h00},
    '{CMD_REGISTER, 32'h0000_0000, 8'h00, 1'b1, ST_OK,   8'h00},
    '{CMD_REGISTER, 32'hFFFF_FFFF, 8'hFF, 1'b1, ST_OK,   8'h00},
    '{CMD_LOOKUP,   32'h0000_0000, 8'h5A, 1'b1, ST_OK,   8'h00},
    '{CMD_LOOKUP,   32'hFFFF_FFFF, 8'h00, 1'b1, ST_OK,   8'hFF},
    // one bit away from a stored key
    '{CMD_LOOKUP,   32'h0000_0001, 8'h00, 1'b1, ST_MISS, 8'h00},
    '{CMD_LOOKUP,   32'hFFFF_FFFE, 8'h00, 1'b1, ST_MISS, 8'h00},
    // re-register keeps the slot, new track
    '{CMD_REGISTER, 32'h0000_0000, 8'hA5, 1'b1, ST_OK,   8'h00},
    '{CMD_LOOKUP,   32'h0000_0000, 8'h00, 1'b0, ST_OK,   8'h00},
    // fill the remaining slots
    '{CMD_REGISTER, 32'h8000_0000, 8'h01, 1'b0, ST_OK,   8'h00},
    '{CMD_REGISTER, 32'h0000_0001, 8'h80, 1'b0, ST_OK,   8'h00},
    '{CMD_REGISTER, 32'h5555_5555, 8'h55, 1'b0, ST_OK,   8'h00},
    '{CMD_REGISTER, 32'hAAAA_AAAA, 8'hAA, 1'b0, ST_OK,   8'h00},
    '{CMD_REGISTER, 32'h1234_5678, 8'h7E, 1'b0, ST_OK,   8'h00},
    '{CMD_REGISTER, 32'h8765_4321, 8'h81, 1'b0, ST_OK,   8'h00},
    // full table: new key rejected, nothing stored
    '{CMD_REGISTER, 32'h0000_0002, 8'h33, 1'b1, ST_FULL, 8'h00},
    '{CMD_LOOKUP,   32'h0000_0002, 8'h33, 1'b1, ST_MISS, 8'h00},
    // known keys still update while full
    '{CMD_REGISTER, 32'h8000_0000, 8'hFE, 1'b0, ST_OK,   8'h00},
    '{CMD_LOOKUP,   32'h8000_0000, 8'h00, 1'b0, ST_OK,   8'h00},
    '{CMD_LOOKUP,   32'h8765_4321, 8'h00, 1'b0, ST_OK,   8'h00},
    '{CMD_REGISTER, 32'hFFFF_FFFF, 8'h00, 1'b0, ST_OK,   8'h00},
    '{CMD_LOOKUP,   32'hFFFF_FFFF, 8'hFF, 1'b0, ST_OK,   8'h00},
    '{CMD_LOOKUP,   32'h0000_0001, 8'h00, 1'b0, ST_OK,   8'h00}
  };

  logic clk;
  logic rst_n;

  sidm_in_if  in_ch ();
  sidm_out_if out_ch ();

  stream_id_map_table i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Shadow copy of the map
  bit               tbl_valid [MAP_ENTRIES];
  logic [KEY_W-1:0] tbl_key   [MAP_ENTRIES];
  logic [TRK_W-1:0] tbl_track [MAP_ENTRIES];

  map_result_t owed_results [$];

  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned results_checked;
  int unsigned hits, misses, rejects;
  int unsigned cycles;
  bit          quiet;
  bit          hold_off_req;
  bit          hold_off_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one command to the shadow map and returns the result it owes.
  function automatic map_result_t lookup_or_register(cmd_e c, logic [KEY_W-1:0] key,
                                                     logic [TRK_W-1:0] trk);
    map_result_t res;
    int          hit_idx;
    int          free_idx;
    res      = '{status: ST_OK, track: '0};
    hit_idx  = -1;
    free_idx = -1;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      if (hit_idx < 0 && tbl_valid[i] && tbl_key[i] == key) hit_idx = i;
      if (free_idx < 0 && !tbl_valid[i]) free_idx = i;
    end
    if (c == CMD_REGISTER) begin
      if (hit_idx >= 0) begin
        tbl_track[hit_idx] = trk;
      end else if (free_idx >= 0) begin
        tbl_valid[free_idx] = 1'b1;
        tbl_key[free_idx]   = key;
        tbl_track[free_idx] = trk;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      if (hit_idx >= 0) res.track = tbl_track[hit_idx];
      else              res.status = ST_MISS;
    end
    return res;
  endfunction

  // Random key currently held in the map (map is never empty here).
  function automatic logic [KEY_W-1:0] known_key();
    int idx;
    idx = $urandom_range(MAP_ENTRIES - 1);
    while (!tbl_valid[idx]) idx = $urandom_range(MAP_ENTRIES - 1);
    return tbl_key[idx];
  endfunction

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Offers one beat, holding valid until it is taken. Entered and left on a rising edge.
  task automatic send_cmd(cmd_e c, logic [KEY_W-1:0] key, logic [TRK_W-1:0] trk,
                          bit pinned, status_e pin_st, logic [TRK_W-1:0] pin_trk);
    map_result_t res;
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.source_id <= key;
    in_ch.track_id  <= trk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    res = lookup_or_register(c, key, trk);
    if (pinned) res = '{status: pin_st, track: pin_trk};
    owed_results.push_back(res);
    beats_sent++;
    if (!quiet && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off so the block backs up.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else if (!quiet && $urandom_range(3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    map_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) begin
        flag_mismatch("result beat with nothing owed, status", 0, out_ch.status);
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        case (want.status)
          ST_OK:   hits++;
          ST_MISS: misses++;
          default: rejects++;
        endcase
        if (out_ch.status !== want.status)
          flag_mismatch("status", want.status, out_ch.status);
        if (out_ch.found_track !== want.track)
          flag_mismatch("found_track", want.track, out_ch.found_track);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, owed_results.size());
      $display("stream_id_map_table: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned      pick;
    int               n;
    cmd_e             c;
    logic [KEY_W-1:0] key;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_REGISTER;
    in_ch.source_id = '0;
    in_ch.track_id  = '0;
    rst_n           = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].trk,
               dir_rows[i].pinned, dir_rows[i].pin_status, dir_rows[i].pin_track);

    // Map is full from here on: mostly hits and updates of stored keys, near misses,
    // and some fresh keys that must bounce off as full.
    for (n = 0; n < RAND_BEATS; n++) begin
      if (n == RAND_BEATS - QUIET_BEATS) quiet = 1'b1;
      if (n == HOLD_AT_BEAT) hold_off_req = 1'b1;
      pick = $urandom_range(99);
      if (pick < 40) begin
        c = CMD_LOOKUP;   key = known_key();
      end else if (pick < 55) begin
        c = CMD_LOOKUP;   key = known_key() ^ (32'd1 << $urandom_range(KEY_W - 1));
      end else if (pick < 65) begin
        c = CMD_LOOKUP;   key = $urandom;
      end else if (pick < 85) begin
        c = CMD_REGISTER; key = known_key();
      end else begin
        c = CMD_REGISTER; key = $urandom;
      end
      send_cmd(c, key, TRK_W'($urandom_range(255)), 1'b0, ST_OK, '0);
    end

    in_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands sent, %0d results checked in %0d cycles", beats_sent,
             results_checked, cycles);
    $display("ok results %0d, lookup misses %0d, full rejects %0d, mismatches %0d",
             hits, misses, rejects, mismatches);
    if (mismatches == 0) begin
      $display("stream_id_map_table: match");
    end else begin
      $display("stream_id_map_table: mismatch");
    end
    $finish;
  end

endmodule
